// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Short wrappers for the concurrent checks used across the resampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_IMPL_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lir_pkg.sv =====
// ---------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, reset values and register indexes shared by the resampler files.
// ---------------------------------------------------------------------------
package lir_pkg;

  // Sample and rate formats
  localparam int SAMPLE_W     = 16;
  localparam int RATE_W       = 18;
  localparam int PHASE_W      = 19;
  localparam int MAX_UPSAMPLE = 32;
  localparam int UPS_W        = $clog2(MAX_UPSAMPLE + 1);
  localparam int LIM_W        = RATE_W + UPS_W;

  // Working phase: one bit above the stored remainder for the running sum
  localparam int R_W = PHASE_W + 1;

  // Interpolation arithmetic
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + RATE_W + 1;
  localparam int DEN_W  = RATE_W + 1;
  localparam int Q_W    = SAMPLE_W + 1;
  localparam int NUM_W  = Q_W + DEN_W;
  localparam int CNT_W  = $clog2(Q_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_RATE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_RATE = CFG_ADDR_W'(1);

endpackage

// ===== sv/linear_interp_resampler_unit.sv =====
// ---------------------------------------------------------------------------
// Linear interpolation resampler
// Rational-phase sample-rate converter for signed Q1.15 audio streams.
// ---------------------------------------------------------------------------
// Each input sample is taken while the block is idle, and the block then
// stays busy until every output it causes has been handed to the output
// register. An interpolated output goes through a phase test, a multiply,
// a divider load, the bit-serial divider and a hand-off of the result that
// also steps the phase; an output that repeats the last sample needs only
// the hand-off, and each hand-off waits while the pending result cannot
// move on. The shared divider takes most of an interpolated output's time.
// Equal rates pass a sample through the pending slot and the flush state.
// The first sample of a buffer that is not also its last is stored and
// gives no output. Outputs of one input leave in order, the last with
// m_tlast set; m_tuser flags the final output of the buffer.
`include "assert_macros.svh"

module linear_interp_resampler_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lir_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_in
  input  logic                                s_tlast,   // final_in
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lir_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] sample_out
  output logic                                m_tlast,   // run_last
  output logic                                m_tuser,   // [0] stream_end
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [lir_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [lir_pkg::RATE_W-1:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_TAIL,
    S_FLUSH
  } state_t;

  state_t state;

  // Configuration
  logic [lir_pkg::RATE_W-1:0]   source_rate;
  logic [lir_pkg::RATE_W-1:0]   target_rate;

  // Stream state
  logic [lir_pkg::SAMPLE_W-1:0] prior_sample;
  logic                         have_prior;
  logic [lir_pkg::PHASE_W-1:0]  phase_rem;

  // Per-item working registers
  logic [lir_pkg::SAMPLE_W-1:0] x_cur;
  logic                         fin_cur;
  logic [lir_pkg::RATE_W-1:0]   from_e;
  logic [lir_pkg::RATE_W-1:0]   to_e;
  logic [lir_pkg::R_W-1:0]      r;
  logic signed [lir_pkg::DIFF_W-1:0] diff;
  logic signed [lir_pkg::PROD_W-1:0] prod;

  // Pending result and output register
  logic                         pend_valid;
  logic [lir_pkg::SAMPLE_W-1:0] pend_sample;
  logic                         out_valid;
  logic [lir_pkg::SAMPLE_W-1:0] out_sample;
  logic                         out_last;
  logic                         out_end;

  // Combinational
  logic [lir_pkg::RATE_W-1:0]   from_raw;
  logic [lir_pkg::RATE_W-1:0]   to_raw;
  logic [lir_pkg::LIM_W-1:0]    up_lim;
  logic [lir_pkg::RATE_W-1:0]   to_clamp;
  logic                         eq_rates;
  logic [lir_pkg::R_W-1:0]      r_plus;
  logic [lir_pkg::R_W-1:0]      r_minus;
  logic                         r_lt_to;
  logic                         interp_put;
  logic                         tail_ok;
  logic                         can_push;
  logic                         slot_ok;
  logic                         gen_fire;
  logic [lir_pkg::SAMPLE_W-1:0] gen_sample;
  logic                         flush_fire;
  logic                         prod_neg;
  logic [lir_pkg::PROD_W-1:0]   prod_mag;
  logic [lir_pkg::NUM_W-1:0]    div_num;
  logic [lir_pkg::DEN_W-1:0]    div_den;
  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [lir_pkg::Q_W-1:0]      div_quot;
  logic [lir_pkg::Q_W:0]        q_s;
  logic [lir_pkg::Q_W:0]        interp_sum;

  // Effective rates: zero acts as one, upsampling limited
  always_comb begin
    from_raw = (source_rate == '0) ? lir_pkg::RATE_W'(1) : source_rate;
    to_raw   = (target_rate == '0) ? lir_pkg::RATE_W'(1) : target_rate;
    up_lim   = lir_pkg::LIM_W'(from_raw) * lir_pkg::LIM_W'(lir_pkg::MAX_UPSAMPLE);
    to_clamp = (lir_pkg::LIM_W'(to_raw) > up_lim) ? up_lim[lir_pkg::RATE_W-1:0] : to_raw;
    eq_rates = (from_raw == to_clamp);
  end

  // Phase arithmetic
  always_comb begin
    r_plus     = r + lir_pkg::R_W'(from_e);
    r_minus    = r - lir_pkg::R_W'(to_e);
    r_lt_to    = (r < lir_pkg::R_W'(to_e));
    interp_put = !fin_cur ||
                 ((lir_pkg::R_W+1)'(r_plus) <= (lir_pkg::R_W+1)'({to_e, 1'b0}));
    tail_ok    = (r_plus <= lir_pkg::R_W'(to_e));
  end

  // Rounded quotient: floor((2*num + to) / (2*to)) through the magnitude
  always_comb begin
    prod_neg = prod[lir_pkg::PROD_W-1];
    prod_mag = prod_neg ? lir_pkg::PROD_W'(-prod) : lir_pkg::PROD_W'(prod);
    div_num  = lir_pkg::NUM_W'({prod_mag, 1'b0}) + lir_pkg::NUM_W'(to_e)
             - lir_pkg::NUM_W'(prod_neg);
    div_den  = {to_e, 1'b0};
    div_start = (state == S_DSTART);
    q_s = prod_neg ? ((lir_pkg::Q_W+1)'(0) - {1'b0, div_quot}) : {1'b0, div_quot};
    interp_sum = {{(lir_pkg::Q_W+1-lir_pkg::SAMPLE_W){prior_sample[lir_pkg::SAMPLE_W-1]}},
                  prior_sample} + q_s;
  end

  // Result hand-off: the newest result waits in the pending slot so the
  // last one of an item can be marked
  always_comb begin
    can_push   = !out_valid || m_tready;
    slot_ok    = !pend_valid || can_push;
    gen_fire   = 1'b0;
    gen_sample = x_cur;
    case (state)
      S_IDLE: begin
        gen_fire   = s_tvalid && eq_rates;
        gen_sample = s_tdata;
      end
      S_DIV: begin
        gen_fire   = div_done && slot_ok;
        gen_sample = interp_sum[lir_pkg::SAMPLE_W-1:0];
      end
      S_TAIL: begin
        gen_fire   = tail_ok && slot_ok;
        gen_sample = x_cur;
      end
      default: begin
        gen_fire   = 1'b0;
        gen_sample = x_cur;
      end
    endcase
    flush_fire = (state == S_FLUSH) && pend_valid && can_push;
  end

  // Shared divider
  lir_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      source_rate  <= lir_pkg::RATE_RESET;
      target_rate  <= lir_pkg::RATE_RESET;
      prior_sample <= '0;
      have_prior   <= 1'b0;
      phase_rem    <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          lir_pkg::REG_SOURCE_RATE: source_rate <= cfg_wdata;
          lir_pkg::REG_TARGET_RATE: target_rate <= cfg_wdata;
          default: ;
        endcase
      end

      // output register
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (gen_fire) begin
        if (pend_valid) begin
          out_valid  <= 1'b1;
          out_sample <= pend_sample;
          out_last   <= 1'b0;
          out_end    <= 1'b0;
        end
        pend_sample <= gen_sample;
        pend_valid  <= 1'b1;
      end
      if (flush_fire) begin
        out_valid  <= 1'b1;
        out_sample <= pend_sample;
        out_last   <= 1'b1;
        out_end    <= fin_cur;
        pend_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x_cur   <= s_tdata;
            fin_cur <= s_tlast;
            from_e  <= from_raw;
            to_e    <= to_clamp;
            r       <= lir_pkg::R_W'(phase_rem);
            diff    <= {s_tdata[lir_pkg::SAMPLE_W-1], s_tdata}
                     - {prior_sample[lir_pkg::SAMPLE_W-1], prior_sample};
            if (eq_rates) begin
              // pass-through; end of buffer still clears the stream
              if (s_tlast) begin
                prior_sample <= '0;
                have_prior   <= 1'b0;
                phase_rem    <= '0;
              end
              state <= S_FLUSH;
            end else if (!have_prior) begin
              if (s_tlast) begin
                state <= S_TAIL;
              end else begin
                prior_sample <= s_tdata;
                have_prior   <= 1'b1;
              end
            end else begin
              state <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (r_lt_to) begin
            if (interp_put) begin
              state <= S_MUL;
            end else begin
              r <= r_plus;
            end
          end else begin
            r <= r_minus;
            if (fin_cur) begin
              state <= S_TAIL;
            end else begin
              prior_sample <= x_cur;
              phase_rem    <= r_minus[lir_pkg::PHASE_W-1:0];
              state        <= S_FLUSH;
            end
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, r[lir_pkg::RATE_W-1:0]});
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done && slot_ok) begin
            r     <= r_plus;
            state <= S_LOOP;
          end
        end
        S_TAIL: begin
          // repeat the last sample up to the end of the buffer
          if (tail_ok) begin
            if (slot_ok) begin
              r <= r_plus;
            end
          end else begin
            prior_sample <= '0;
            have_prior   <= 1'b0;
            phase_rem    <= '0;
            state        <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid || can_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tlast  = out_last;
  assign m_tuser  = out_end;

  // Checks
  `ASSERT_IMPL(a_idle_drained, clk, rst, state == S_IDLE, !pend_valid, "result left pending in idle")
  `ASSERT_IMPL(a_end_is_last, clk, rst, m_tvalid && m_tuser, m_tlast, "buffer end not on last result")
  `ASSERT_IMPL(a_phase_clear, clk, rst, (state == S_IDLE) && !have_prior, phase_rem == '0, "phase kept without a stored sample")
  `ASSERT_IMPL(a_div_wait, clk, rst, div_start, !div_busy, "divider restarted while busy")

endmodule

// ===== sv/lir_div.sv =====
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring long division, one quotient bit per clock.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lir_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lir_pkg::NUM_W-1:0]       num,
  input  logic [lir_pkg::DEN_W-1:0]       den,
  output logic                            busy,
  output logic                            done,
  output logic [lir_pkg::Q_W-1:0]         quot
);

  logic [lir_pkg::DEN_W-1:0] rem;
  logic [lir_pkg::Q_W-1:0]   shreg;
  logic [lir_pkg::CNT_W-1:0] cnt;
  logic [lir_pkg::DEN_W:0]   trial;
  logic                      qbit;

  // Bring down the next numerator bit and try the subtract
  always_comb begin
    trial = {rem, shreg[lir_pkg::Q_W-1]};
    qbit  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      // quotient fits in Q_W bits, so the top bits start as the remainder
      rem   <= num[lir_pkg::NUM_W-1:lir_pkg::Q_W];
      shreg <= num[lir_pkg::Q_W-1:0];
      cnt   <= lir_pkg::CNT_W'(lir_pkg::Q_W);
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      rem   <= qbit ? lir_pkg::DEN_W'(trial - {1'b0, den}) : trial[lir_pkg::DEN_W-1:0];
      shreg <= {shreg[lir_pkg::Q_W-2:0], qbit};
      cnt   <= cnt - 1'b1;
      if (cnt == lir_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = shreg;

  // Checks
  `ASSERT_IMPL_NEXT(a_div_start, clk, rst, start, busy && !done, "divider did not start")
  `ASSERT_ALWAYS(a_div_excl, clk, rst, !(busy && done), "divider busy and done together")

endmodule

// ===== bench/lir_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Resampler stream checker
// Watches the configuration port and both stream channels of the resampler,
// predicts the output samples of every accepted input sample on its own
// copy of the rate registers and stream state, and compares each output
// transfer field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module lir_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [lir_pkg::SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_in
  input  logic                           s_tlast,    // final_in
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [lir_pkg::SAMPLE_W-1:0]   m_tdata,    // [15:0] sample_out
  input  logic                           m_tlast,    // run_last
  input  logic                           m_tuser,    // [0] stream_end
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lir_pkg::RATE_W-1:0]     cfg_wdata,
  output int                             errors,
  output int                             outstanding
);

  import lir_pkg::*;

  // One input sample never yields more outputs than this
  localparam int MAX_OUTPUTS = 2 * MAX_UPSAMPLE;
  // Stop printing after this many mismatches, keep counting
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                run_last;
    logic                stream_end;
  } out_word_t;

  // Shadow registers and stream state
  logic [RATE_W-1:0]   src_rate;
  logic [RATE_W-1:0]   dst_rate;
  logic [SAMPLE_W-1:0] held_sample;
  logic                held_valid;
  logic [PHASE_W-1:0]  phase_acc;

  out_word_t due_samples[$];
  int        made;

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    if (errors < PRINT_CAP)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic void restart_stream();
    held_sample = '0;
    held_valid  = 1'b0;
    phase_acc   = '0;
  endfunction

  function automatic void queue_sample(input longint v);
    out_word_t w;
    if (made < MAX_OUTPUTS) begin
      w.smp        = v[SAMPLE_W-1:0];
      w.run_last   = 1'b0;
      w.stream_end = 1'b0;
      due_samples  = {due_samples, w};
      made++;
    end
  endfunction

  // Outputs caused by one input sample, in order, with the state update
  function automatic void interpolate_step(input logic [SAMPLE_W-1:0] smp, input logic fin);
    longint    step, span, r, xv, a, diff, num, den, q;
    out_word_t tail;
    xv   = longint'($signed(smp));
    step = (src_rate == '0) ? 64'sd1 : longint'(src_rate);
    span = (dst_rate == '0) ? 64'sd1 : longint'(dst_rate);
    if (span > MAX_UPSAMPLE * step) span = MAX_UPSAMPLE * step;
    r    = longint'(phase_acc);
    made = 0;

    if (step == span) begin
      // equal rates: straight through, state kept unless the buffer ends
      queue_sample(xv);
      if (fin) restart_stream();
    end else if (!held_valid) begin
      if (fin) begin
        // lone sample that also ends the buffer
        while (r + step <= span) begin
          queue_sample(xv);
          r += step;
        end
        restart_stream();
      end else begin
        held_sample = smp;
        held_valid  = 1'b1;
      end
    end else begin
      a    = longint'($signed(held_sample));
      diff = xv - a;
      // interval between the held sample and this one
      while (r < span) begin
        if (!fin || r + step <= 2 * span) begin
          num = 2 * diff * r + span;
          den = 2 * span;
          q   = num / den;
          if ((num % den) != 0 && num < 0) q -= 1;
          queue_sample(a + q);
        end
        r += step;
      end
      r -= span;
      if (fin) begin
        // tail of the buffer repeats the last sample
        while (r + step <= span) begin
          queue_sample(xv);
          r += step;
        end
        restart_stream();
      end else begin
        held_sample = smp;
        phase_acc   = r[PHASE_W-1:0];
      end
    end

    if (made > 0) begin
      tail            = due_samples.pop_back();
      tail.run_last   = 1'b1;
      tail.stream_end = fin;
      due_samples     = {due_samples, tail};
    end
  endfunction

  // Output side first: a result never leaves at the edge its input is taken
  always @(posedge clk) begin
    if (rst) begin
      src_rate = RATE_RESET;
      dst_rate = RATE_RESET;
      restart_stream();
      due_samples.delete();
      errors   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_samples.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata, '0);
        end else begin
          out_word_t w;
          w = due_samples.pop_front();
          if (m_tdata !== w.smp)
            report_mismatch("sample_out", m_tdata, w.smp);
          if (m_tlast !== w.run_last)
            report_mismatch("run_last", SAMPLE_W'(m_tlast), SAMPLE_W'(w.run_last));
          if (m_tuser !== w.stream_end)
            report_mismatch("stream_end", SAMPLE_W'(m_tuser), SAMPLE_W'(w.stream_end));
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_SOURCE_RATE) src_rate = cfg_wdata;
        else if (cfg_addr == REG_TARGET_RATE) dst_rate = cfg_wdata;
      end
      if (s_tvalid && s_tready)
        interpolate_step(s_tdata, s_tlast);
    end
    outstanding = due_samples.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Resampler testbench
// Drives sample buffers through the linear interpolation resampler under a
// series of rate settings, with random gaps on the input and random back
// pressure on the output. The checker beside the block predicts and
// compares every output transfer; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;

  import lir_pkg::*;

  // Worst single item: 32 interpolated outputs and 32 repeats, with a
  // wide margin
  localparam int SETTLE_CYCLES = 1500;
  // Cycles with no transfer on either side before giving up
  localparam int QUIET_LIMIT   = 20000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata;    // [15:0] sample_in
  logic                  s_tlast;    // final_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [SAMPLE_W-1:0]   m_tdata;    // [15:0] sample_out
  logic                  m_tlast;    // run_last
  logic                  m_tuser;    // [0] stream_end
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [RATE_W-1:0]     cfg_wdata;

  int errors;
  int outstanding;
  int sent;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  linear_interp_resampler_unit dut (.*);

  lir_checker checker_i (.*);

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Output back pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on transfers
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idling profile follows the number of samples sent so far
  function automatic void pick_idling();
    if (sent < 125) begin
      send_idle_pct = 33;
      recv_idle_pct = 76;
    end else if (sent < 250) begin
      send_idle_pct = 76;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // One input transfer, with a random gap ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= fin;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent++;
    pick_idling();
  endtask

  // Hold the input until every predicted output has gone
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Rates change only once the block has gone quiet
  task automatic set_rates(input int src, input int dst);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SOURCE_RATE;
    cfg_wdata <= RATE_W'(src);
    @(posedge clk);
    cfg_addr  <= REG_TARGET_RATE;
    cfg_wdata <= RATE_W'(dst);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return SAMPLE_W'($urandom_range(16)) - 16'd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Buffers of random length; the last one may be left open across the
  // next rate change
  task automatic run_phase(input int src, input int dst, input int items);
    int   left;
    int   len;
    logic close;
    set_rates(src, dst);
    left = items;
    while (left > 0) begin
      len   = $urandom_range(12, 1);
      close = 1'b1;
      if (len >= left) begin
        len   = left;
        close = 1'($urandom_range(1));
      end
      for (int j = 0; j < len; j++)
        send_sample(random_sample(), close && (j == len - 1));
      left -= len;
      if ($urandom_range(19) == 0) drain_outputs();
    end
  endtask

  initial begin
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tlast       <= 1'b0;
    m_tready      <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_SOURCE_RATE;
    cfg_wdata     <= '0;
    sent          = 0;
    pick_idling();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Equal rates out of reset: extremes pass straight through
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'd12345, 1'b1);

    // Upsampling clamped to 32x: lone final sample, full-scale swings
    set_rates(1, 192000);
    send_sample(16'd7, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);

    // Extreme downsampling: buffer ends with no flagged output
    set_rates(192000, 1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'd300, 1'b1);
    send_sample(16'd400, 1'b1);

    // Zero rates act as one
    set_rates(0, 0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'd9, 1'b1);
    set_rates(0, 3);
    send_sample(16'd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    // rate change with a buffer still open
    set_rates(2, 0);
    send_sample(16'd50, 1'b0);
    send_sample(16'd60, 1'b1);

    // Random buffers over a spread of ratios
    run_phase(44100, 16000, 45);
    run_phase(16000, 48000, 45);
    run_phase(48000, 44100, 45);
    run_phase(3, 7, 35);
    run_phase(0, 5, 20);
    run_phase(192000, 1, 15);
    run_phase(11025, 8000, 35);
    run_phase(8000, 11025, 35);
    run_phase(7, 0, 20);
    run_phase(192000, 192000, 25);
    run_phase(1, 192000, 8);
    run_phase(96000, 191999, 25);
    run_phase(5, 160, 12);

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lir_pkg.sv
sv/lir_div.sv
sv/linear_interp_resampler_unit.sv
bench/lir_checker.sv
bench/testbench.sv
